// ===== rtl/stpf_pkg.sv =====
// Shared types and constants for the scale and translation point fit block.
// Used by the controller, the datapath, the divider and the top level.
`timescale 1ns / 1ps

package stpf_pkg;

   // Point store depth and the widths that follow from it.
   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Small divider: dividend width and quotient bits retired per cycle.
   localparam int DIV_W     = 60;
   localparam int DIV_DIGIT = 4;

   // Iteration counts of the scale divider and the square root.
   localparam int SDIV_STEPS = 24;
   localparam int SQRT_STEPS = 30;
   localparam int STEP_W     = 5;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_MUL,
      OP_ACC,
      OP_PROD,
      OP_DIFF,
      OP_DINIT,
      OP_DSTEP,
      OP_SCALE,
      OP_BASE,
      OP_BASE2,
      OP_PMUL,
      OP_PADD,
      OP_PDIV,
      OP_PWR,
      OP_PSQ,
      OP_PACC,
      OP_RDIV,
      OP_SINIT,
      OP_SSTEP,
      OP_SFIN,
      OP_EOUT
   } op_type;

   // Controller states.
   typedef enum logic [4:0] {
      S_IDLE,
      S_MUL,
      S_ACC,
      S_PROD,
      S_DIFF,
      S_DINIT,
      S_DSTEP,
      S_SCALE,
      S_BASE,
      S_BASE2,
      S_PRD,
      S_PMUL,
      S_PADD,
      S_PDIV,
      S_PWAIT,
      S_PWR,
      S_PSQ,
      S_PACC,
      S_RDIV,
      S_RWAIT,
      S_SINIT,
      S_SSTEP,
      S_SFIN,
      S_ERD,
      S_EOUT
   } state_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic   cap;
      op_type op;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic set_end;
      logic k_last;
      logic div_done;
   } stat_type;

endpackage

// ===== rtl/scale_translate_point_fit.sv =====
// Top level of the least-squares scale and translation point fit.
// Depends on stpf_pkg, stpf_ctrl and stpf_dp.
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+--------------------------
//   request   | req_tmpl_x/y, req_obs_x/y, req_set_end  | start high while busy low
//   result    | rsp_fit_x/y, rsp_fit_scale, rsp_rms_error,
//             | rsp_degenerate, rsp_run_end             | rsp_strobe, one cycle each
//
// A request that does not end a set passes the multiply and accumulate states; the next
// request can be taken in the accumulate state. A set-ending request runs 24 scale
// divider steps, a divider wait per point, 30 root steps and a read and output per result.
// Reset is synchronous and clears the sums and pair count; stores need no clearing.
// Results cannot be stalled: each is on the ports for exactly one cycle.
`timescale 1ns / 1ps

module scale_translate_point_fit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_tmpl_x,
   input  logic signed [23:0] req_tmpl_y,
   input  logic signed [23:0] req_obs_x,
   input  logic signed [23:0] req_obs_y,
   input  logic               req_set_end,
   output logic               rsp_strobe,
   output logic signed [23:0] rsp_fit_x,
   output logic signed [23:0] rsp_fit_y,
   output logic signed [23:0] rsp_fit_scale,
   output logic [23:0]        rsp_rms_error,
   output logic               rsp_degenerate,
   output logic               rsp_run_end
);
   import stpf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   stpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .stat       (stat)
   );

   stpf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_tmpl_x     (req_tmpl_x),
      .req_tmpl_y     (req_tmpl_y),
      .req_obs_x      (req_obs_x),
      .req_obs_y      (req_obs_y),
      .req_set_end    (req_set_end),
      .rsp_fit_x      (rsp_fit_x),
      .rsp_fit_y      (rsp_fit_y),
      .rsp_fit_scale  (rsp_fit_scale),
      .rsp_rms_error  (rsp_rms_error),
      .rsp_degenerate (rsp_degenerate),
      .rsp_run_end    (rsp_run_end)
   );

endmodule

// ===== rtl/stpf_ndiv.sv =====
// Iterative unsigned divider by a small count, four quotient bits per cycle.
// Depends on stpf_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module stpf_ndiv (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [stpf_pkg::DIV_W-1:0]  dividend,
   input  logic [stpf_pkg::CNT_W-1:0]  divisor,
   output logic [stpf_pkg::DIV_W-1:0]  quotient,
   output logic                        done
);
   import stpf_pkg::*;

   localparam int STEPS = DIV_W / DIV_DIGIT;
   localparam int SC_W  = $clog2(STEPS + 1);

   logic [SC_W-1:0]  cnt_ff;
   logic             done_ff;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;

   // One group of restoring steps: the remainder stays below the divisor.
   always_comb begin
      logic [CNT_W:0] r8;
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int j = 0; j < DIV_DIGIT; j++) begin
         r8     = {rem_in, quo_in[DIV_W-1]};
         quo_in = {quo_in[DIV_W-2:0], 1'b0};
         if (r8 >= {1'b0, divisor}) begin
            r8        = r8 - {1'b0, divisor};
            quo_in[0] = 1'b1;
         end
         rem_in = r8[CNT_W-1:0];
      end
   end

   // Step counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= SC_W'(STEPS);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_ff - 1'b1;
         done_ff <= (cnt_ff == SC_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   // Remainder and quotient shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/stpf_dp.sv =====
// Datapath of the point fit: point stores, sums, scale divider, fit loop and root.
// Depends on stpf_pkg and instantiates two stpf_ndiv dividers.
`timescale 1ns / 1ps

module stpf_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  stpf_pkg::cmd_type       cmd,
   output stpf_pkg::stat_type      stat,
   input  logic signed [23:0]      req_tmpl_x,
   input  logic signed [23:0]      req_tmpl_y,
   input  logic signed [23:0]      req_obs_x,
   input  logic signed [23:0]      req_obs_y,
   input  logic                    req_set_end,
   output logic signed [23:0]      rsp_fit_x,
   output logic signed [23:0]      rsp_fit_y,
   output logic signed [23:0]      rsp_fit_scale,
   output logic [23:0]             rsp_rms_error,
   output logic                    rsp_degenerate,
   output logic                    rsp_run_end
);
   import stpf_pkg::*;

   // Captured request.
   logic signed [23:0] qx_ff, qy_ff, px_ff, py_ff;
   logic               end_ff;

   // Per-pair products and running sums.
   logic signed [47:0] cdx_ff, cdy_ff, qqx_ff, qqy_ff;
   logic signed [29:0] sum_qx_ff, sum_qy_ff, sum_px_ff, sum_py_ff;
   logic signed [55:0] sum_cd_ff, sum_qq_ff;
   logic [CNT_W-1:0]   n_ff;

   // Scale numerator and denominator.
   logic signed [63:0] p_ncd_ff, p_nqq_ff;
   logic signed [59:0] p_xx_ff, p_yy_ff, p_qxx_ff, p_qyy_ff;
   logic signed [63:0] num_ff, den_ff;

   // Scale divider.
   logic               deg_ff, neg_s_ff, sat_s_ff;
   logic [70:0]        rem_ff, dvs_ff;
   logic [23:0]        quo_s_ff;
   logic signed [23:0] s_ff;

   // Offset terms and fit loop.
   logic signed [31:0] ns_ff;
   logic signed [53:0] tsx_ff, tsy_ff;
   logic signed [55:0] bx_ff, by_ff;
   logic [IDX_W-1:0]   k_ff;
   logic [47:0]        tmpl_rd_ff, obs_rd_ff, fit_rd_ff;
   logic signed [55:0] mx_ff, my_ff;
   logic signed [56:0] ax_ff, ay_ff;
   logic               negx_ff, negy_ff;
   logic signed [23:0] fx_ff, fy_ff;
   logic [49:0]        sqdx_ff, sqdy_ff;
   logic [57:0]        resid_ff;

   // Square root.
   logic [57:0]        sqv_ff;
   logic [58:0]        sqres_ff, sqbit_ff;
   logic [23:0]        rms_ff;

   // Memories.
   logic [47:0] tmpl_mem [MAX_POINTS];
   logic [47:0] obs_mem  [MAX_POINTS];
   logic [47:0] fit_mem  [MAX_POINTS];

   // Combinational helpers.
   logic               full;
   logic               k_last;
   logic signed [7:0]  n_s;
   logic [57:0]        half;
   logic [56:0]        magx, magy;
   logic [57:0]        adx, ady;
   logic [DIV_W-1:0]   divx_in, divy_in, quox, quoy;
   logic               donex, doney;
   logic               startx, starty;
   logic [23:0]        fitx_w, fity_w;
   logic [63:0]        mag_num;
   logic [70:0]        r2;
   logic [23:0]        mag_s;
   logic signed [23:0] s_in;
   logic signed [24:0] dxv, dyv;
   logic [59:0]        sq_t;

   // Saturated signed fit value from a rounded quotient magnitude and its sign.
   function automatic logic [23:0] sat_fit(input logic neg, input logic [DIV_W-1:0] q);
      logic [23:0] r;
      if (!neg) begin
         r = (q > DIV_W'(24'h7FFFFF)) ? 24'h7FFFFF : q[23:0];
      end else begin
         r = (q >= DIV_W'(24'h800000)) ? 24'h800000 : 24'd0 - q[23:0];
      end
      return r;
   endfunction

   assign full    = (n_ff == CNT_W'(MAX_POINTS));
   assign k_last  = ({1'b0, k_ff} == n_ff - CNT_W'(1));
   assign n_s     = signed'(8'({1'b0, n_ff}));
   assign half    = 58'({n_ff, 15'b0});

   // Dividends for the fit divisions: |a| + n*2^15, then drop 16 bits.
   assign magx    = ax_ff[56] ? 57'(-ax_ff) : 57'(ax_ff);
   assign magy    = ay_ff[56] ? 57'(-ay_ff) : 57'(ay_ff);
   assign adx     = {1'b0, magx} + half;
   assign ady     = {1'b0, magy} + half;
   assign divx_in = (cmd.op == OP_RDIV) ? DIV_W'(resid_ff) : DIV_W'(adx[57:16]);
   assign divy_in = DIV_W'(ady[57:16]);
   assign startx  = (cmd.op == OP_PDIV) || (cmd.op == OP_RDIV);
   assign starty  = (cmd.op == OP_PDIV);

   stpf_ndiv u_ndiv_x (
      .clock    (clock),
      .reset    (reset),
      .start    (startx),
      .dividend (divx_in),
      .divisor  (n_ff),
      .quotient (quox),
      .done     (donex)
   );

   stpf_ndiv u_ndiv_y (
      .clock    (clock),
      .reset    (reset),
      .start    (starty),
      .dividend (divy_in),
      .divisor  (n_ff),
      .quotient (quoy),
      .done     (doney)
   );

   assign fitx_w = sat_fit(negx_ff, quox);
   assign fity_w = sat_fit(negy_ff, quoy);

   // Scale divider step and final rounding.
   assign mag_num = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
   assign r2      = {rem_ff[69:0], 1'b0};
   assign mag_s   = 24'((25'(quo_s_ff) + 25'd1) >> 1);

   always_comb begin
      if (deg_ff) begin
         s_in = '0;
      end else if (sat_s_ff) begin
         s_in = neg_s_ff ? 24'sh800000 : 24'sh7FFFFF;
      end else if (neg_s_ff) begin
         s_in = mag_s[23] ? 24'sh800000 : signed'(24'd0 - mag_s);
      end else begin
         s_in = mag_s[23] ? 24'sh7FFFFF : signed'(mag_s);
      end
   end

   // Residual terms and root trial value.
   assign dxv  = 25'(signed'(obs_rd_ff[23:0])) - 25'(fx_ff);
   assign dyv  = 25'(signed'(obs_rd_ff[47:24])) - 25'(fy_ff);
   assign sq_t = {1'b0, sqres_ff} + {1'b0, sqbit_ff};

   // Control-side state: sums, pair count and loop index.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_qx_ff <= '0;
         sum_qy_ff <= '0;
         sum_px_ff <= '0;
         sum_py_ff <= '0;
         sum_cd_ff <= '0;
         sum_qq_ff <= '0;
         n_ff      <= '0;
         k_ff      <= '0;
         end_ff    <= 1'b0;
      end else begin
         if (cmd.cap) begin
            end_ff <= req_set_end;
         end
         case (cmd.op) inside
            OP_ACC: begin
               if (!full) begin
                  sum_qx_ff <= sum_qx_ff + 30'(qx_ff);
                  sum_qy_ff <= sum_qy_ff + 30'(qy_ff);
                  sum_px_ff <= sum_px_ff + 30'(px_ff);
                  sum_py_ff <= sum_py_ff + 30'(py_ff);
                  sum_cd_ff <= sum_cd_ff + 56'(cdx_ff) + 56'(cdy_ff);
                  sum_qq_ff <= sum_qq_ff + 56'(qqx_ff) + 56'(qqy_ff);
                  n_ff      <= n_ff + CNT_W'(1);
               end
            end
            OP_BASE2, OP_SFIN: k_ff <= '0;
            OP_PACC:  k_ff <= k_ff + IDX_W'(1);
            OP_EOUT: begin
               k_ff <= k_ff + IDX_W'(1);
               if (k_last) begin
                  sum_qx_ff <= '0;
                  sum_qy_ff <= '0;
                  sum_px_ff <= '0;
                  sum_py_ff <= '0;
                  sum_cd_ff <= '0;
                  sum_qq_ff <= '0;
                  n_ff      <= '0;
                  k_ff      <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Payload registers of the arithmetic steps.
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         qx_ff <= req_tmpl_x;
         qy_ff <= req_tmpl_y;
         px_ff <= req_obs_x;
         py_ff <= req_obs_y;
      end
      case (cmd.op)
         OP_MUL: begin
            cdx_ff <= 48'(qx_ff * px_ff);
            cdy_ff <= 48'(qy_ff * py_ff);
            qqx_ff <= 48'(qx_ff * qx_ff);
            qqy_ff <= 48'(qy_ff * qy_ff);
         end
         OP_PROD: begin
            p_ncd_ff <= 64'(n_s * sum_cd_ff);
            p_nqq_ff <= 64'(n_s * sum_qq_ff);
            p_xx_ff  <= 60'(sum_qx_ff * sum_px_ff);
            p_yy_ff  <= 60'(sum_qy_ff * sum_py_ff);
            p_qxx_ff <= 60'(sum_qx_ff * sum_qx_ff);
            p_qyy_ff <= 60'(sum_qy_ff * sum_qy_ff);
         end
         OP_DIFF: begin
            num_ff <= p_ncd_ff - 64'(p_xx_ff) - 64'(p_yy_ff);
            den_ff <= p_nqq_ff - 64'(p_qxx_ff) - 64'(p_qyy_ff);
         end
         OP_DINIT: begin
            deg_ff   <= den_ff[63] || (den_ff == '0);
            neg_s_ff <= num_ff[63];
            rem_ff   <= 71'(mag_num);
            dvs_ff   <= {den_ff, 7'b0};
            sat_s_ff <= (71'(mag_num) >= {den_ff, 7'b0});
            quo_s_ff <= '0;
         end
         OP_DSTEP: begin
            if (r2 >= dvs_ff) begin
               rem_ff   <= r2 - dvs_ff;
               quo_s_ff <= {quo_s_ff[22:0], 1'b1};
            end else begin
               rem_ff   <= r2;
               quo_s_ff <= {quo_s_ff[22:0], 1'b0};
            end
         end
         OP_SCALE: s_ff <= s_in;
         OP_BASE: begin
            ns_ff  <= 32'(n_s * s_ff);
            tsx_ff <= 54'(s_ff * sum_qx_ff);
            tsy_ff <= 54'(s_ff * sum_qy_ff);
         end
         OP_BASE2: begin
            bx_ff    <= (56'(sum_px_ff) <<< 16) - 56'(tsx_ff);
            by_ff    <= (56'(sum_py_ff) <<< 16) - 56'(tsy_ff);
            resid_ff <= '0;
         end
         OP_PMUL: begin
            mx_ff <= 56'(ns_ff * signed'(tmpl_rd_ff[23:0]));
            my_ff <= 56'(ns_ff * signed'(tmpl_rd_ff[47:24]));
         end
         OP_PADD: begin
            ax_ff <= 57'(mx_ff) + 57'(bx_ff);
            ay_ff <= 57'(my_ff) + 57'(by_ff);
         end
         OP_PDIV: begin
            negx_ff <= ax_ff[56];
            negy_ff <= ay_ff[56];
         end
         OP_PWR: begin
            fx_ff <= signed'(fitx_w);
            fy_ff <= signed'(fity_w);
         end
         OP_PSQ: begin
            sqdx_ff <= unsigned'(50'(dxv * dxv));
            sqdy_ff <= unsigned'(50'(dyv * dyv));
         end
         OP_PACC: resid_ff <= resid_ff + 58'(sqdx_ff) + 58'(sqdy_ff);
         OP_SINIT: begin
            sqv_ff   <= quox[57:0];
            sqres_ff <= '0;
            sqbit_ff <= 59'(1) << (2 * (SQRT_STEPS - 1));
         end
         OP_SSTEP: begin
            if ({2'b0, sqv_ff} >= sq_t) begin
               sqv_ff   <= 58'({2'b0, sqv_ff} - sq_t);
               sqres_ff <= (sqres_ff >> 1) + sqbit_ff;
            end else begin
               sqres_ff <= sqres_ff >> 1;
            end
            sqbit_ff <= sqbit_ff >> 2;
         end
         OP_SFIN: rms_ff <= (sqres_ff > 59'(24'hFFFFFF)) ? 24'hFFFFFF : sqres_ff[23:0];
         default: ;
      endcase
   end

   // Point stores and fit store, each read at the loop index.
   always_ff @(posedge clock) begin
      if ((cmd.op == OP_MUL) && !full) begin
         tmpl_mem[n_ff[IDX_W-1:0]] <= {qy_ff, qx_ff};
         obs_mem[n_ff[IDX_W-1:0]]  <= {py_ff, px_ff};
      end
      if (cmd.op == OP_PWR) begin
         fit_mem[k_ff] <= {fity_w, fitx_w};
      end
      tmpl_rd_ff <= tmpl_mem[k_ff];
      obs_rd_ff  <= obs_mem[k_ff];
      fit_rd_ff  <= fit_mem[k_ff];
   end

   assign stat.set_end  = end_ff;
   assign stat.k_last   = k_last;
   assign stat.div_done = donex;

   assign rsp_fit_x      = signed'(fit_rd_ff[23:0]);
   assign rsp_fit_y      = signed'(fit_rd_ff[47:24]);
   assign rsp_fit_scale  = s_ff;
   assign rsp_rms_error  = rms_ff;
   assign rsp_degenerate = deg_ff;
   assign rsp_run_end    = k_last;

   // The pair count never passes the store depth.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(MAX_POINTS))
      else $error("pair count above store depth");

   // Both dividers of a point finish together.
   a_div_pair: assert property (@(posedge clock) disable iff (reset)
      $past(starty) |-> !donex || doney)
      else $error("fit dividers out of step");

   // A dropped pair leaves the count unchanged.
   a_drop: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_ACC) && full |=> n_ff == CNT_W'(MAX_POINTS))
      else $error("pair counted past full store");

endmodule

// ===== rtl/stpf_ctrl.sv =====
// Controller of the point fit: sequences loading, scale, fit loop, root and output.
// Depends on stpf_pkg for states, commands and status.
`timescale 1ns / 1ps

module stpf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_strobe,
   output stpf_pkg::cmd_type   cmd,
   input  stpf_pkg::stat_type  stat
);
   import stpf_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // State and iteration counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd.cap    = 1'b0;
      cmd.op     = OP_NONE;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.cap  = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.op   = OP_MUL;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = OP_ACC;
            if (stat.set_end) begin
               state_in = S_PROD;
            end else begin
               busy = 1'b0;
               if (start) begin
                  cmd.cap  = 1'b1;
                  state_in = S_MUL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_PROD: begin
            cmd.op   = OP_PROD;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.op   = OP_DINIT;
            step_in  = STEP_W'(SDIV_STEPS - 1);
            state_in = S_DSTEP;
         end
         S_DSTEP: begin
            cmd.op  = OP_DSTEP;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = S_BASE;
         end
         S_BASE: begin
            cmd.op   = OP_BASE;
            state_in = S_BASE2;
         end
         S_BASE2: begin
            cmd.op   = OP_BASE2;
            state_in = S_PRD;
         end
         S_PRD: begin
            state_in = S_PMUL;
         end
         S_PMUL: begin
            cmd.op   = OP_PMUL;
            state_in = S_PADD;
         end
         S_PADD: begin
            cmd.op   = OP_PADD;
            state_in = S_PDIV;
         end
         S_PDIV: begin
            cmd.op   = OP_PDIV;
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            if (stat.div_done) begin
               state_in = S_PWR;
            end
         end
         S_PWR: begin
            cmd.op   = OP_PWR;
            state_in = S_PSQ;
         end
         S_PSQ: begin
            cmd.op   = OP_PSQ;
            state_in = S_PACC;
         end
         S_PACC: begin
            cmd.op   = OP_PACC;
            state_in = stat.k_last ? S_RDIV : S_PRD;
         end
         S_RDIV: begin
            cmd.op   = OP_RDIV;
            state_in = S_RWAIT;
         end
         S_RWAIT: begin
            if (stat.div_done) begin
               state_in = S_SINIT;
            end
         end
         S_SINIT: begin
            cmd.op   = OP_SINIT;
            step_in  = STEP_W'(SQRT_STEPS - 1);
            state_in = S_SSTEP;
         end
         S_SSTEP: begin
            cmd.op  = OP_SSTEP;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = S_SFIN;
            end
         end
         S_SFIN: begin
            cmd.op   = OP_SFIN;
            state_in = S_ERD;
         end
         S_ERD: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            cmd.op     = OP_EOUT;
            rsp_strobe = 1'b1;
            state_in   = stat.k_last ? S_IDLE : S_ERD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Results appear only during a fit run.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // An accepted request always makes the block busy next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted without going busy");

   // Results are spaced by a store read state.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back to back result strobes");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for scale_translate_point_fit.
// Depends on stpf_pkg and the block's RTL. It predicts the least-squares fit of every
// point set, compares each result strobe with the prediction, and uses random pacing.
`timescale 1ns / 1ps

// One fitted point as seen on the result ports.
typedef struct {
   logic signed [23:0] fit_x;
   logic signed [23:0] fit_y;
   logic signed [23:0] scale;
   logic [23:0]        rms;
   logic               degenerate;
   logic               run_end;
} fit_point_type;

// Predicts fitted points for each set and checks results in order.
class fit_scoreboard;
   fit_point_type pending_fits[$];
   longint tmpl_x_mem[stpf_pkg::MAX_POINTS], tmpl_y_mem[stpf_pkg::MAX_POINTS];
   longint obs_x_mem[stpf_pkg::MAX_POINTS], obs_y_mem[stpf_pkg::MAX_POINTS];
   longint acc_tx, acc_ty, acc_ox, acc_oy, acc_dot, acc_tsq;
   int     pairs;
   int     errors;

   function new();
      clear_set();
      errors = 0;
   endfunction

   function void clear_set();
      acc_tx = 0; acc_ty = 0; acc_ox = 0; acc_oy = 0; acc_dot = 0; acc_tsq = 0;
      pairs = 0;
   endfunction

   // Division rounded to nearest, ties away from zero, positive divisor.
   function longint round_div(longint a, longint d);
      longint unsigned m;
      longint unsigned q;
      m = (a < 0) ? longint'(-a) : a;
      q = (m + longint'(d) / 2) / longint'(d);
      return (a < 0) ? -longint'(q) : longint'(q);
   endfunction

   function longint clip24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // Q7.16 quotient with rounding and saturation.
   function longint scale_quotient(longint num, longint den);
      longint unsigned m, ud, ip, r, frac, mag;
      logic neg;
      neg = num < 0;
      m = neg ? longint'(-num) : num;
      ud = den;
      ip = m / ud;
      r = m % ud;
      frac = 0;
      if (ip >= 128) return neg ? -8388608 : 8388607;
      for (int i = 0; i < 17; i++) begin
         r = r << 1;
         frac = frac << 1;
         if (r >= ud) begin
            r = r - ud;
            frac = frac | 1;
         end
      end
      mag = (((ip << 17) | frac) + 1) >> 1;
      if (neg) return (mag >= 8388608) ? -8388608 : -longint'(mag);
      return (mag > 8388607) ? 8388607 : longint'(mag);
   endfunction

   function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Notes one accepted request; a set-ending request queues the whole fit.
   function void note_request(logic signed [23:0] tx, logic signed [23:0] ty,
                              logic signed [23:0] ox, logic signed [23:0] oy, logic last);
      longint n, num, den, s, base_x, base_y, dv, dx, dy;
      longint fx[stpf_pkg::MAX_POINTS], fy[stpf_pkg::MAX_POINTS];
      longint unsigned resid, rms;
      logic degen;
      fit_point_type r;
      if (pairs < stpf_pkg::MAX_POINTS) begin
         tmpl_x_mem[pairs] = tx; tmpl_y_mem[pairs] = ty;
         obs_x_mem[pairs] = ox;  obs_y_mem[pairs] = oy;
         acc_tx += tx; acc_ty += ty; acc_ox += ox; acc_oy += oy;
         acc_dot += longint'(tx) * ox + longint'(ty) * oy;
         acc_tsq += longint'(tx) * tx + longint'(ty) * ty;
         pairs++;
      end
      if (!last) return;
      n = pairs;
      num = n * acc_dot - (acc_tx * acc_ox + acc_ty * acc_oy);
      den = n * acc_tsq - (acc_tx * acc_tx + acc_ty * acc_ty);
      degen = den <= 0;
      s = degen ? 0 : scale_quotient(num, den);
      base_x = acc_ox * 65536 - s * acc_tx;
      base_y = acc_oy * 65536 - s * acc_ty;
      dv = n * 65536;
      resid = 0;
      for (int k = 0; k < pairs; k++) begin
         fx[k] = clip24(round_div(n * s * tmpl_x_mem[k] + base_x, dv));
         fy[k] = clip24(round_div(n * s * tmpl_y_mem[k] + base_y, dv));
         dx = obs_x_mem[k] - fx[k];
         dy = obs_y_mem[k] - fy[k];
         resid += longint'(dx * dx) + longint'(dy * dy);
      end
      rms = int_sqrt(resid / longint'(n));
      if (rms > 24'hFFFFFF) rms = 24'hFFFFFF;
      for (int k = 0; k < pairs; k++) begin
         r.fit_x = 24'(fx[k]);
         r.fit_y = 24'(fy[k]);
         r.scale = 24'(s);
         r.rms = 24'(rms);
         r.degenerate = degen;
         r.run_end = (k + 1 == pairs);
         pending_fits.push_back(r);
      end
      clear_set();
   endfunction

   // Compares one result strobe with the oldest predicted point.
   function void check_result(fit_point_type got);
      fit_point_type want;
      if (pending_fits.size() == 0) begin
         $display("%0t: unexpected result fit=(%0d,%0d)", $time, got.fit_x, got.fit_y);
         errors++;
         return;
      end
      want = pending_fits.pop_front();
      if (got.fit_x !== want.fit_x) begin
         $display("%0t: fit_x expected %0d actual %0d", $time, want.fit_x, got.fit_x);
         errors++;
      end
      if (got.fit_y !== want.fit_y) begin
         $display("%0t: fit_y expected %0d actual %0d", $time, want.fit_y, got.fit_y);
         errors++;
      end
      if (got.scale !== want.scale) begin
         $display("%0t: fit_scale expected %0d actual %0d", $time, want.scale, got.scale);
         errors++;
      end
      if (got.rms !== want.rms) begin
         $display("%0t: rms_error expected %0d actual %0d", $time, want.rms, got.rms);
         errors++;
      end
      if (got.degenerate !== want.degenerate) begin
         $display("%0t: degenerate expected %0b actual %0b", $time, want.degenerate,
                  got.degenerate);
         errors++;
      end
      if (got.run_end !== want.run_end) begin
         $display("%0t: run_end expected %0b actual %0b", $time, want.run_end,
                  got.run_end);
         errors++;
      end
   endfunction
endclass

module tb;
   localparam int STALL_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [23:0] req_tmpl_x = '0, req_tmpl_y = '0, req_obs_x = '0, req_obs_y = '0;
   logic               req_set_end = 1'b0;
   logic               rsp_strobe;
   logic signed [23:0] rsp_fit_x, rsp_fit_y, rsp_fit_scale;
   logic [23:0]        rsp_rms_error;
   logic               rsp_degenerate, rsp_run_end;

   fit_scoreboard fits = new();
   int  idle_cycles = 0;
   int  burst_left = 0;

   scale_translate_point_fit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_tmpl_x(req_tmpl_x), .req_tmpl_y(req_tmpl_y),
      .req_obs_x(req_obs_x), .req_obs_y(req_obs_y), .req_set_end(req_set_end),
      .rsp_strobe(rsp_strobe), .rsp_fit_x(rsp_fit_x), .rsp_fit_y(rsp_fit_y),
      .rsp_fit_scale(rsp_fit_scale), .rsp_rms_error(rsp_rms_error),
      .rsp_degenerate(rsp_degenerate), .rsp_run_end(rsp_run_end)
   );

   always #6 clock = ~clock;

   // Result monitor and stall watchdog.
   always @(posedge clock) begin
      fit_point_type got;
      if (!reset && rsp_strobe) begin
         got.fit_x = rsp_fit_x;
         got.fit_y = rsp_fit_y;
         got.scale = rsp_fit_scale;
         got.rms = rsp_rms_error;
         got.degenerate = rsp_degenerate;
         got.run_end = rsp_run_end;
         fits.check_result(got);
      end
      if (reset || rsp_strobe || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("scale_translate_point_fit regression: fail");
         $finish;
      end
   end

   // Sender pacing: bursts of random length separated by random gaps.
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   // Presents one request and waits until the block takes it.
   task automatic send_pair(logic signed [23:0] tx, logic signed [23:0] ty,
                            logic signed [23:0] ox, logic signed [23:0] oy, logic last);
      start <= 1'b1;
      req_tmpl_x <= tx;
      req_tmpl_y <= ty;
      req_obs_x <= ox;
      req_obs_y <= oy;
      req_set_end <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      fits.note_request(tx, ty, ox, oy, last);
      pace();
   endtask

   function automatic logic signed [23:0] sat_coord(longint v);
      if (v > 8388607) return 24'sh7FFFFF;
      if (v < -8388608) return 24'sh800000;
      return 24'(v);
   endfunction

   // One point set: mostly observed = k*template + offset + noise, some raw noise.
   task automatic send_set(int len);
      longint k_num, off_x, off_y, tx, ty;
      int mag, noise;
      logic raw;
      raw = ($urandom_range(0, 4) == 0);
      k_num = $signed($urandom_range(0, 1024)) - 512;
      off_x = $signed($urandom_range(0, 2000000)) - 1000000;
      off_y = $signed($urandom_range(0, 2000000)) - 1000000;
      mag = ($urandom_range(0, 5) == 0) ? 8388607 : $urandom_range(16, 1000000);
      noise = $urandom_range(0, 4000);
      for (int i = 0; i < len; i++) begin
         if (raw) begin
            send_pair(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                      i == len - 1);
         end else begin
            tx = $signed($urandom_range(0, 2 * mag)) - mag;
            ty = $signed($urandom_range(0, 2 * mag)) - mag;
            send_pair(24'(tx), 24'(ty),
                      sat_coord(tx * k_num / 128 + off_x +
                                $signed($urandom_range(0, 2 * noise)) - noise),
                      sat_coord(ty * k_num / 128 + off_y +
                                $signed($urandom_range(0, 2 * noise)) - noise),
                      i == len - 1);
         end
      end
   endtask

   initial begin
      int sent;
      int len;
      int waited;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single pair: zero denominator, extremes of every coordinate.
      send_pair(24'sh7FFFFF, -24'sd8388608, -24'sd8388608, 24'sh7FFFFF, 1'b1);
      // Two pairs at opposite corners, all zeros.
      send_pair(-24'sd8388608, -24'sd8388608, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
      send_pair(24'sh7FFFFF, 24'sh7FFFFF, -24'sd8388608, -24'sd8388608, 1'b1);
      send_pair(24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0);
      send_pair(24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1);
      // Identical templates give a degenerate fit to the observed mean.
      send_pair(24'sd4096, -24'sd4096, 24'sd100, 24'sd7, 1'b0);
      send_pair(24'sd4096, -24'sd4096, -24'sd3, 24'sd1000, 1'b0);
      send_pair(24'sd4096, -24'sd4096, 24'sd8, -24'sd50, 1'b1);
      // A huge scale saturates, then exact scale two with offset.
      send_pair(24'sd0, 24'sd0, -24'sd8388608, 24'sd0, 1'b0);
      send_pair(24'sd1, 24'sd0, 24'sh7FFFFF, 24'sd0, 1'b1);
      send_pair(24'sd4096, 24'sd8192, 24'sd8292, 24'sd16484, 1'b0);
      send_pair(-24'sd4096, 24'sd0, -24'sd8092, 24'sd100, 1'b1);
      // Set too long: pairs past the store depth are dropped.
      for (int i = 0; i < stpf_pkg::MAX_POINTS + 2; i++)
         send_pair(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                   i == stpf_pkg::MAX_POINTS + 1);

      // Random sets, mostly short, a few at full depth.
      sent = 0;
      while (sent < 230) begin
         case ($urandom_range(0, 19))
            0:       len = stpf_pkg::MAX_POINTS;
            1, 2, 3: len = $urandom_range(9, 24);
            default: len = $urandom_range(1, 8);
         endcase
         send_set(len);
         sent += len;
      end
      start <= 1'b0;

      waited = 0;
      while (fits.pending_fits.size() != 0 && waited < STALL_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (fits.errors == 0 && fits.pending_fits.size() == 0) begin
         $display("scale_translate_point_fit regression: pass");
      end else begin
         $display("scale_translate_point_fit regression: fail");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/stpf_pkg.sv
rtl/stpf_ndiv.sv
rtl/stpf_dp.sv
rtl/stpf_ctrl.sv
rtl/scale_translate_point_fit.sv
sim/tb.sv
